### hw/rtl/ymodem_sender_controller_core_macros.svh
// ----------------------------------------------------------------------------
// ysc assertion macros
// shared property templates for the sender controller checks
// ----------------------------------------------------------------------------
`ifndef YMODEM_SENDER_CONTROLLER_CORE_MACROS_SVH
`define YMODEM_SENDER_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define YSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ysc check failed");

// next-cycle implication
`define YSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ysc check failed");

`endif

### hw/rtl/ysc_pkg.sv
// ----------------------------------------------------------------------------
// ysc_pkg
// types and constants of the ymodem batch sender controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ysc_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_END    = 3'd1;
  localparam logic [2:0] CMD_BYTE   = 3'd2;
  localparam logic [2:0] CMD_TICK   = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;

  localparam logic [7:0] BYTE_C   = 8'h43;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_ACK = 8'h06;

  localparam logic [31:0] BLK_LONG  = 32'd1024;
  localparam logic [31:0] BLK_SHORT = 32'd128;

  localparam logic CFG_TIMEOUT_TICKS = 1'b0;
  localparam logic CFG_RETRY_LIMIT   = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WAIT_REQ, MODE_HDR_ACK, MODE_DATA_REQ,
    MODE_DATA_ACK, MODE_EOT_ACK, MODE_CLOSE_ACK
  } mode_t;

  typedef enum logic [2:0] {
    ACT_HDR, ACT_DATA, ACT_EOT, ACT_CLOSE, ACT_CAN, ACT_FILE_DONE, ACT_BATCH
  } action_t;

  typedef enum logic [2:0] {
    FAIL_NONE, FAIL_NO_REQ, FAIL_HDR, FAIL_DATA_REQ,
    FAIL_DATA, FAIL_EOT, FAIL_CLOSE, FAIL_CANCELLED
  } fail_t;

  typedef enum logic [2:0] {
    EV_START, EV_END, EV_C, EV_NAK, EV_ACK, EV_TICK, EV_CANCEL
  } ev_t;

  typedef struct packed {
    ev_t         ev;
    logic [31:0] file_size;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qport_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  seq;
    logic        long_block;
    logic [31:0] data_offset;
    logic [10:0] data_len;
    fail_t       fail_reason;
  } result_t;

endpackage

### hw/rtl/ysc_if.sv
// ----------------------------------------------------------------------------
// ysc channel interfaces
// valid/ready channels for command words and action words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ysc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  rx_byte;
  logic [31:0] file_size;

  modport source (output valid, cmd, rx_byte, file_size, input ready);
  modport sink   (input valid, cmd, rx_byte, file_size, output ready);
endinterface

interface ysc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  seq;
  logic        long_block;
  logic [31:0] data_offset;
  logic [10:0] data_len;
  logic [2:0]  fail_reason;

  modport source (output valid, action, seq, long_block, data_offset, data_len,
                  fail_reason, input ready);
  modport sink   (input valid, action, seq, long_block, data_offset, data_len,
                  fail_reason, output ready);
endinterface

### hw/rtl/ymodem_sender_controller_core.sv
// ----------------------------------------------------------------------------
// ymodem_sender_controller_core
// a taken command word passes the event queue and then the action word register
// throughput: one command word per cycle while the event queue is not full
// the event queue lets input keep flowing while an action word is held
// reset: rst_n synchronous active low; idle, queue empty, default config
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ymodem_sender_controller_core_macros.svh"

module ymodem_sender_controller_core #(
  parameter int QUEUE_DEPTH = ysc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  ysc_in_if.sink      in_ch,
  ysc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]     timeout_ticks_r;
  logic [7:0]      retry_limit_r;
  logic            q_push, q_full, q_pop;
  ysc_pkg::entry_t q_entry;
  ysc_pkg::qport_t q_head;
  logic            out_can, out_cancelled, out_other, out_blank, out_data, out_len_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= 32'd3000;
      retry_limit_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ysc_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        ysc_pkg::CFG_RETRY_LIMIT:   retry_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ysc_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  ysc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  ysc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_ticks_r),
    .retry_limit   (retry_limit_r),
    .head          (q_head),
    .q_pop         (q_pop),
    .out_ch        (out_ch)
  );

  assign out_can       = out_ch.valid && (out_ch.action == ysc_pkg::ACT_CAN);
  assign out_cancelled = (out_ch.fail_reason == ysc_pkg::FAIL_CANCELLED);
  assign out_other     = out_ch.valid && (out_ch.action != ysc_pkg::ACT_DATA);
  assign out_blank     = (out_ch.data_len == 11'd0) && (out_ch.data_offset == 32'd0);
  assign out_data      = out_ch.valid && (out_ch.action == ysc_pkg::ACT_DATA);
  assign out_len_ok    = (out_ch.data_len <= 11'd1024) &&
                         (!out_ch.long_block || out_ch.data_len == 11'd1024);

  `YSC_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, q_full, !q_push)
  `YSC_ASSERT_IMPLIES(a_can_reason, clk, rst_n, out_can, out_cancelled)
  `YSC_ASSERT_IMPLIES(a_nondata_zero, clk, rst_n, out_other, out_blank)
  `YSC_ASSERT_IMPLIES(a_block_len, clk, rst_n, out_data, out_len_ok)
  `YSC_ASSERT_NEXT(a_pop_empty, clk, rst_n, !q_head.valid && !q_push, !q_head.valid)

endmodule

### hw/rtl/ysc_front.sv
// ----------------------------------------------------------------------------
// ysc_front
// accepts command words and classifies them into events for the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ysc_front (
  ysc_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output ysc_pkg::entry_t q_entry
);

  logic keep;

  assign in_ch.ready = !q_full;

  // unknown commands and received bytes other than C, NAK and ACK are dropped here
  always_comb begin
    keep = 1'b1;
    q_entry.ev = ysc_pkg::EV_START;
    q_entry.file_size = in_ch.file_size;
    unique case (in_ch.cmd)
      ysc_pkg::CMD_START:  q_entry.ev = ysc_pkg::EV_START;
      ysc_pkg::CMD_END:    q_entry.ev = ysc_pkg::EV_END;
      ysc_pkg::CMD_TICK:   q_entry.ev = ysc_pkg::EV_TICK;
      ysc_pkg::CMD_CANCEL: q_entry.ev = ysc_pkg::EV_CANCEL;
      ysc_pkg::CMD_BYTE: begin
        if (in_ch.rx_byte == ysc_pkg::BYTE_C) begin
          q_entry.ev = ysc_pkg::EV_C;
        end else if (in_ch.rx_byte == ysc_pkg::BYTE_NAK) begin
          q_entry.ev = ysc_pkg::EV_NAK;
        end else if (in_ch.rx_byte == ysc_pkg::BYTE_ACK) begin
          q_entry.ev = ysc_pkg::EV_ACK;
        end else begin
          keep = 1'b0;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_ch.valid && !q_full && keep;

endmodule

### hw/rtl/ysc_queue.sv
// ----------------------------------------------------------------------------
// ysc_queue
// short event queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ysc_queue #(
  parameter int DEPTH = ysc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ysc_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output ysc_pkg::qport_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ysc_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/ysc_back.sv
// ----------------------------------------------------------------------------
// ysc_back
// transfer state machine, retry and timer logic, action word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ysc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     timeout_ticks,
  input  logic [7:0]      retry_limit,
  input  ysc_pkg::qport_t head,
  output logic            q_pop,
  ysc_out_if.source       out_ch
);

  ysc_pkg::mode_t   mode_r, mode_nxt;
  logic [7:0]       retry_r, retry_nxt;
  logic [31:0]      timer_left_r, timer_left_nxt;
  logic             timer_on_r, timer_on_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      sent_r, sent_nxt;
  logic [7:0]       next_seq_r, next_seq_nxt;
  logic [31:0]      last_off_r, last_off_nxt;
  logic [10:0]      last_len_r, last_len_nxt;
  logic             last_long_r, last_long_nxt;
  logic             out_valid_r;
  ysc_pkg::result_t out_data_r;

  logic             res_valid;
  ysc_pkg::result_t res;
  logic [8:0]       retry_inc;
  logic             retry_ok;
  logic             tick_live, tick_fire, file_done, is_idle;
  logic [31:0]      rem;
  logic             blk_long;
  logic [10:0]      blk_len;
  logic             do_start, do_emit, do_fail, do_resend, do_send;
  ysc_pkg::action_t emit_act;
  ysc_pkg::fail_t   fail_why;
  ysc_pkg::ev_t     ev;

  assign ev = head.entry.ev;
  assign q_pop = head.valid && (!out_valid_r || out_ch.ready);
  assign retry_inc = {1'b0, retry_r} + 9'd1;
  assign retry_ok = (retry_inc <= {1'b0, retry_limit});
  assign is_idle = (mode_r == ysc_pkg::MODE_IDLE);
  assign tick_live = !is_idle && timer_on_r;
  assign tick_fire = tick_live && (timer_left_r <= 32'd1);
  assign file_done = (sent_r >= size_r);
  assign rem = size_r - sent_r;
  assign blk_long = (rem >= ysc_pkg::BLK_LONG);
  assign blk_len = blk_long ? ysc_pkg::BLK_LONG[10:0]
                 : ((rem < ysc_pkg::BLK_SHORT) ? rem[10:0] : ysc_pkg::BLK_SHORT[10:0]);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (q_pop) begin
      unique case (ev)
        ysc_pkg::EV_START: if (is_idle) mode_nxt = ysc_pkg::MODE_WAIT_REQ;
        ysc_pkg::EV_END:   if (is_idle) mode_nxt = ysc_pkg::MODE_CLOSE_ACK;
        ysc_pkg::EV_CANCEL: mode_nxt = ysc_pkg::MODE_IDLE;
        ysc_pkg::EV_C: begin
          if (mode_r == ysc_pkg::MODE_WAIT_REQ) begin
            mode_nxt = ysc_pkg::MODE_HDR_ACK;
          end else if (mode_r == ysc_pkg::MODE_DATA_REQ) begin
            mode_nxt = file_done ? ysc_pkg::MODE_EOT_ACK : ysc_pkg::MODE_DATA_ACK;
          end
        end
        ysc_pkg::EV_NAK: begin
          if (mode_r == ysc_pkg::MODE_WAIT_REQ) begin
            mode_nxt = ysc_pkg::MODE_HDR_ACK;
          end else if (!retry_ok && (mode_r == ysc_pkg::MODE_HDR_ACK ||
                       mode_r == ysc_pkg::MODE_DATA_ACK ||
                       mode_r == ysc_pkg::MODE_EOT_ACK ||
                       mode_r == ysc_pkg::MODE_CLOSE_ACK)) begin
            mode_nxt = ysc_pkg::MODE_IDLE;
          end
        end
        ysc_pkg::EV_ACK: begin
          unique case (mode_r)
            ysc_pkg::MODE_HDR_ACK:   mode_nxt = ysc_pkg::MODE_DATA_REQ;
            ysc_pkg::MODE_DATA_ACK:
              mode_nxt = file_done ? ysc_pkg::MODE_EOT_ACK : ysc_pkg::MODE_DATA_ACK;
            ysc_pkg::MODE_EOT_ACK:   mode_nxt = ysc_pkg::MODE_IDLE;
            ysc_pkg::MODE_CLOSE_ACK: mode_nxt = ysc_pkg::MODE_IDLE;
            default: ;
          endcase
        end
        ysc_pkg::EV_TICK: if (tick_fire && !retry_ok) mode_nxt = ysc_pkg::MODE_IDLE;
        default: ;
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    do_start = 1'b0;
    do_emit = 1'b0;
    do_fail = 1'b0;
    do_resend = 1'b0;
    do_send = 1'b0;
    emit_act = ysc_pkg::ACT_HDR;
    fail_why = ysc_pkg::FAIL_NONE;
    res_valid = 1'b0;
    res = '0;
    retry_nxt = retry_r;
    timer_left_nxt = timer_left_r;
    timer_on_nxt = timer_on_r;
    size_nxt = size_r;
    sent_nxt = sent_r;
    next_seq_nxt = next_seq_r;
    last_off_nxt = last_off_r;
    last_len_nxt = last_len_r;
    last_long_nxt = last_long_r;

    if (q_pop) begin
      unique case (ev)
        ysc_pkg::EV_START: begin
          if (is_idle) begin
            size_nxt = head.entry.file_size;
            sent_nxt = '0;
            next_seq_nxt = 8'd1;
            retry_nxt = '0;
            do_start = 1'b1;
          end
        end
        ysc_pkg::EV_END: begin
          if (is_idle) begin
            retry_nxt = '0;
            do_start = 1'b1;
            do_emit = 1'b1;
            emit_act = ysc_pkg::ACT_CLOSE;
          end
        end
        ysc_pkg::EV_CANCEL: begin
          if (!is_idle) begin
            timer_on_nxt = 1'b0;
            timer_left_nxt = '0;
            retry_nxt = '0;
            res_valid = 1'b1;
            res.action = ysc_pkg::ACT_CAN;
            res.fail_reason = ysc_pkg::FAIL_CANCELLED;
          end
        end
        ysc_pkg::EV_C: begin
          if (mode_r == ysc_pkg::MODE_WAIT_REQ) begin
            retry_nxt = '0;
            do_start = 1'b1;
            do_emit = 1'b1;
            emit_act = ysc_pkg::ACT_HDR;
          end else if (mode_r == ysc_pkg::MODE_DATA_REQ) begin
            do_send = 1'b1;
          end
        end
        ysc_pkg::EV_NAK: begin
          unique case (mode_r)
            ysc_pkg::MODE_WAIT_REQ: begin
              retry_nxt = '0;
              do_start = 1'b1;
              do_emit = 1'b1;
              emit_act = ysc_pkg::ACT_HDR;
            end
            ysc_pkg::MODE_DATA_REQ: do_start = 1'b1;
            ysc_pkg::MODE_HDR_ACK, ysc_pkg::MODE_EOT_ACK, ysc_pkg::MODE_CLOSE_ACK: begin
              if (retry_ok) begin
                retry_nxt = retry_inc[7:0];
                do_start = 1'b1;
                do_emit = 1'b1;
                emit_act = (mode_r == ysc_pkg::MODE_HDR_ACK) ? ysc_pkg::ACT_HDR
                         : (mode_r == ysc_pkg::MODE_EOT_ACK) ? ysc_pkg::ACT_EOT
                         : ysc_pkg::ACT_CLOSE;
              end else begin
                do_fail = 1'b1;
                fail_why = (mode_r == ysc_pkg::MODE_HDR_ACK) ? ysc_pkg::FAIL_HDR
                         : (mode_r == ysc_pkg::MODE_EOT_ACK) ? ysc_pkg::FAIL_EOT
                         : ysc_pkg::FAIL_CLOSE;
              end
            end
            ysc_pkg::MODE_DATA_ACK: begin
              if (retry_ok) begin
                retry_nxt = retry_inc[7:0];
                do_resend = 1'b1;
              end else begin
                do_fail = 1'b1;
                fail_why = ysc_pkg::FAIL_DATA;
              end
            end
            default: ;
          endcase
        end
        ysc_pkg::EV_ACK: begin
          unique case (mode_r)
            ysc_pkg::MODE_HDR_ACK: begin
              retry_nxt = '0;
              do_start = 1'b1;
            end
            ysc_pkg::MODE_DATA_ACK: do_send = 1'b1;
            ysc_pkg::MODE_EOT_ACK: begin
              timer_on_nxt = 1'b0;
              timer_left_nxt = '0;
              retry_nxt = '0;
              do_emit = 1'b1;
              emit_act = ysc_pkg::ACT_FILE_DONE;
            end
            ysc_pkg::MODE_CLOSE_ACK: begin
              do_fail = 1'b1;
              fail_why = ysc_pkg::FAIL_NONE;
            end
            default: ;
          endcase
        end
        ysc_pkg::EV_TICK: begin
          if (tick_live) begin
            if (!tick_fire) begin
              timer_left_nxt = timer_left_r - 32'd1;
            end else begin
              timer_left_nxt = '0;
              timer_on_nxt = 1'b0;
              if (!retry_ok) begin
                do_fail = 1'b1;
                fail_why = ysc_pkg::fail_t'(3'(mode_r));
              end else begin
                retry_nxt = retry_inc[7:0];
                unique case (mode_r)
                  ysc_pkg::MODE_DATA_ACK: do_resend = 1'b1;
                  ysc_pkg::MODE_HDR_ACK: begin
                    do_start = 1'b1;
                    do_emit = 1'b1;
                    emit_act = ysc_pkg::ACT_HDR;
                  end
                  ysc_pkg::MODE_EOT_ACK: begin
                    do_start = 1'b1;
                    do_emit = 1'b1;
                    emit_act = ysc_pkg::ACT_EOT;
                  end
                  ysc_pkg::MODE_CLOSE_ACK: begin
                    do_start = 1'b1;
                    do_emit = 1'b1;
                    emit_act = ysc_pkg::ACT_CLOSE;
                  end
                  default: do_start = 1'b1;
                endcase
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (do_start || do_resend || do_send) begin
      timer_left_nxt = timeout_ticks;
      timer_on_nxt = 1'b1;
    end
    if (do_emit) begin
      res_valid = 1'b1;
      res.action = emit_act;
    end
    if (do_fail) begin
      timer_on_nxt = 1'b0;
      timer_left_nxt = '0;
      retry_nxt = '0;
      res_valid = 1'b1;
      res.action = ysc_pkg::ACT_BATCH;
      res.fail_reason = fail_why;
    end
    if (do_resend) begin
      res_valid = 1'b1;
      res.action = ysc_pkg::ACT_DATA;
      res.seq = next_seq_r - 8'd1;
      res.long_block = last_long_r;
      res.data_offset = last_off_r;
      res.data_len = last_len_r;
    end
    if (do_send) begin
      retry_nxt = '0;
      res_valid = 1'b1;
      if (file_done) begin
        res.action = ysc_pkg::ACT_EOT;
      end else begin
        last_long_nxt = blk_long;
        last_off_nxt = sent_r;
        last_len_nxt = blk_len;
        sent_nxt = sent_r + {21'd0, blk_len};
        next_seq_nxt = next_seq_r + 8'd1;
        res.action = ysc_pkg::ACT_DATA;
        res.seq = next_seq_r;
        res.long_block = blk_long;
        res.data_offset = sent_r;
        res.data_len = blk_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ysc_pkg::MODE_IDLE;
      retry_r <= '0;
      timer_left_r <= '0;
      timer_on_r <= 1'b0;
      size_r <= '0;
      sent_r <= '0;
      next_seq_r <= 8'd1;
      last_off_r <= '0;
      last_len_r <= '0;
      last_long_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      retry_r <= retry_nxt;
      timer_left_r <= timer_left_nxt;
      timer_on_r <= timer_on_nxt;
      size_r <= size_nxt;
      sent_r <= sent_nxt;
      next_seq_r <= next_seq_nxt;
      last_off_r <= last_off_nxt;
      last_len_r <= last_len_nxt;
      last_long_r <= last_long_nxt;
      if (q_pop && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.action = out_data_r.action;
  assign out_ch.seq = out_data_r.seq;
  assign out_ch.long_block = out_data_r.long_block;
  assign out_ch.data_offset = out_data_r.data_offset;
  assign out_ch.data_len = out_data_r.data_len;
  assign out_ch.fail_reason = out_data_r.fail_reason;

endmodule

### tb/tb_ymodem_sender_controller_core.sv
// ----------------------------------------------------------------------------
// tb_ymodem_sender_controller_core
// drives command words into the ymodem batch sender controller and checks
// every action word against a cycle-free prediction of the transfer states,
// under random gaps and stalls on both channels and several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import ysc_pkg::*;

class sender_action_scoreboard;
  localparam int REPORT_CAP = 40;

  logic [31:0] tick_limit;
  logic [7:0]  retry_limit;

  mode_t       mode;
  logic [7:0]  retry_count;
  logic [31:0] timer_left;
  logic        timer_on;
  logic [31:0] size_of_file;
  logic [31:0] bytes_sent;
  logic [7:0]  next_seq;
  logic [31:0] last_offset;
  logic [10:0] last_len;
  logic        last_long;

  result_t due_actions[$];
  int      mismatches;
  int      words_in;
  int      words_out;
  int      seen[7];
  int      failed_batches;

  function new();
    tick_limit   = 32'd3000;
    retry_limit  = 8'd10;
    mode         = MODE_IDLE;
    retry_count  = '0;
    timer_left   = '0;
    timer_on     = 1'b0;
    size_of_file = '0;
    bytes_sent   = '0;
    next_seq     = 8'd1;
    last_offset  = '0;
    last_len     = '0;
    last_long    = 1'b0;
    mismatches   = 0;
    words_in     = 0;
    words_out    = 0;
    failed_batches = 0;
    foreach (seen[i]) seen[i] = 0;
  endfunction

  function int pending();
    return due_actions.size();
  endfunction

  function void set_reg(logic idx, logic [31:0] value);
    if (idx == CFG_TIMEOUT_TICKS) tick_limit = value;
    else retry_limit = value[7:0];
  endfunction

  function void push_action(action_t act, logic [7:0] sq, logic lg, logic [31:0] off,
                            logic [10:0] len, fail_t why);
    result_t r;
    r.action      = act;
    r.seq         = sq;
    r.long_block  = lg;
    r.data_offset = off;
    r.data_len    = len;
    r.fail_reason = why;
    due_actions.push_back(r);
  endfunction

  function void enter_mode(mode_t m);
    mode = m;
    retry_count = '0;
  endfunction

  function void load_timer();
    timer_left = tick_limit;
    timer_on = 1'b1;
  endfunction

  function void stop_timer();
    timer_on = 1'b0;
    timer_left = '0;
  endfunction

  function void fail_with(fail_t why);
    stop_timer();
    enter_mode(MODE_IDLE);
    push_action(ACT_BATCH, '0, 1'b0, '0, '0, why);
  endfunction

  function bit retry_allowed();
    logic [8:0] n;
    n = {1'b0, retry_count} + 9'd1;
    if (n > {1'b0, retry_limit}) return 1'b0;
    retry_count = n[7:0];
    return 1'b1;
  endfunction

  function void resend_block();
    load_timer();
    push_action(ACT_DATA, next_seq - 8'd1, last_long, last_offset, last_len, FAIL_NONE);
  endfunction

  function void send_next_block();
    logic [31:0] rest;
    logic [31:0] blk;
    logic [31:0] len;
    load_timer();
    if (bytes_sent >= size_of_file) begin
      enter_mode(MODE_EOT_ACK);
      push_action(ACT_EOT, '0, 1'b0, '0, '0, FAIL_NONE);
      return;
    end
    rest = size_of_file - bytes_sent;
    last_long = rest >= BLK_LONG;
    blk = last_long ? BLK_LONG : BLK_SHORT;
    len = (rest < blk) ? rest : blk;
    last_offset = bytes_sent;
    last_len = len[10:0];
    bytes_sent = bytes_sent + len;
    next_seq = next_seq + 8'd1;
    enter_mode(MODE_DATA_ACK);
    resend_block();
  endfunction

  function void take_byte(logic [7:0] b);
    bit nak;
    bit ack;
    nak = (b == BYTE_NAK);
    ack = (b == BYTE_ACK);
    case (mode)
      MODE_WAIT_REQ: begin
        if (b == BYTE_C || nak) begin
          enter_mode(MODE_HDR_ACK);
          load_timer();
          push_action(ACT_HDR, '0, 1'b0, '0, '0, FAIL_NONE);
        end
      end
      MODE_HDR_ACK: begin
        if (ack) begin
          enter_mode(MODE_DATA_REQ);
          load_timer();
        end else if (nak) begin
          if (!retry_allowed()) fail_with(FAIL_HDR);
          else begin
            load_timer();
            push_action(ACT_HDR, '0, 1'b0, '0, '0, FAIL_NONE);
          end
        end
      end
      MODE_DATA_REQ: begin
        if (b == BYTE_C) send_next_block();
        else if (nak) load_timer();
      end
      MODE_DATA_ACK: begin
        if (ack) send_next_block();
        else if (nak) begin
          if (!retry_allowed()) fail_with(FAIL_DATA);
          else resend_block();
        end
      end
      MODE_EOT_ACK: begin
        if (ack) begin
          stop_timer();
          enter_mode(MODE_IDLE);
          push_action(ACT_FILE_DONE, '0, 1'b0, '0, '0, FAIL_NONE);
        end else if (nak) begin
          if (!retry_allowed()) fail_with(FAIL_EOT);
          else begin
            load_timer();
            push_action(ACT_EOT, '0, 1'b0, '0, '0, FAIL_NONE);
          end
        end
      end
      MODE_CLOSE_ACK: begin
        if (ack) fail_with(FAIL_NONE);
        else if (nak) begin
          if (!retry_allowed()) fail_with(FAIL_CLOSE);
          else begin
            load_timer();
            push_action(ACT_CLOSE, '0, 1'b0, '0, '0, FAIL_NONE);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void time_out();
    // modes and fail reasons share their order
    if (!retry_allowed()) begin
      fail_with(fail_t'(mode));
      return;
    end
    load_timer();
    case (mode)
      MODE_HDR_ACK:   push_action(ACT_HDR, '0, 1'b0, '0, '0, FAIL_NONE);
      MODE_DATA_ACK:  resend_block();
      MODE_EOT_ACK:   push_action(ACT_EOT, '0, 1'b0, '0, '0, FAIL_NONE);
      MODE_CLOSE_ACK: push_action(ACT_CLOSE, '0, 1'b0, '0, '0, FAIL_NONE);
      default: ;
    endcase
  endfunction

  // returns 1 for start and end words while idle, and for byte, tick and cancel words otherwise
  function bit note_word(logic [2:0] cmd, logic [7:0] rx, logic [31:0] fsz);
    bit counted;
    words_in++;
    counted = (mode == MODE_IDLE) ? (cmd == CMD_START || cmd == CMD_END)
                                  : (cmd == CMD_BYTE || cmd == CMD_TICK || cmd == CMD_CANCEL);
    case (cmd)
      CMD_START: begin
        if (mode == MODE_IDLE) begin
          size_of_file = fsz;
          bytes_sent = '0;
          next_seq = 8'd1;
          enter_mode(MODE_WAIT_REQ);
          load_timer();
        end
      end
      CMD_END: begin
        if (mode == MODE_IDLE) begin
          enter_mode(MODE_CLOSE_ACK);
          load_timer();
          push_action(ACT_CLOSE, '0, 1'b0, '0, '0, FAIL_NONE);
        end
      end
      CMD_BYTE: take_byte(rx);
      CMD_TICK: begin
        if (mode != MODE_IDLE && timer_on) begin
          if (timer_left > 32'd1) timer_left = timer_left - 32'd1;
          else begin
            stop_timer();
            time_out();
          end
        end
      end
      CMD_CANCEL: begin
        if (mode != MODE_IDLE) begin
          stop_timer();
          enter_mode(MODE_IDLE);
          push_action(ACT_CAN, '0, 1'b0, '0, '0, FAIL_CANCELLED);
        end
      end
      default: ;
    endcase
    return counted;
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
  endtask

  task check_word(result_t got);
    result_t want;
    words_out++;
    if (got.action <= ACT_BATCH) seen[got.action]++;
    if (got.action == ACT_BATCH && got.fail_reason != FAIL_NONE) failed_batches++;
    if (due_actions.size() == 0) begin
      report($sformatf("action word %0d arrived with none due", got.action));
      return;
    end
    want = due_actions.pop_front();
    if (got.action !== want.action)
      report($sformatf("word %0d action %0d, want %0d", words_out, got.action, want.action));
    if (got.seq !== want.seq)
      report($sformatf("word %0d seq %0d, want %0d", words_out, got.seq, want.seq));
    if (got.long_block !== want.long_block)
      report($sformatf("word %0d long_block %0b, want %0b", words_out, got.long_block,
                       want.long_block));
    if (got.data_offset !== want.data_offset)
      report($sformatf("word %0d data_offset %0h, want %0h", words_out, got.data_offset,
                       want.data_offset));
    if (got.data_len !== want.data_len)
      report($sformatf("word %0d data_len %0d, want %0d", words_out, got.data_len,
                       want.data_len));
    if (got.fail_reason !== want.fail_reason)
      report($sformatf("word %0d fail_reason %0d, want %0d", words_out, got.fail_reason,
                       want.fail_reason));
  endtask
endclass

module tb_ymodem_sender_controller_core;
  localparam int RESET_CYCLES     = 7;
  localparam int SETTLE_CYCLES    = 16;
  localparam int DRAIN_LIMIT      = 4000;
  localparam int HOLD_CYCLES      = 120;
  localparam int PHASES           = 8;
  localparam int PRESSURE_PHASE   = 3;
  localparam int WORDS_PER_PHASE  = 72;
  localparam int WATCHDOG_NS      = 10_000_000;

  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  ysc_in_if  in_ch ();
  ysc_out_if out_ch ();

  ymodem_sender_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sender_action_scoreboard sb;

  bit rush;
  bit hold_request;
  int holds_done;
  int settings_used;
  int send_spell;
  bit send_quiet;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_word(input logic [2:0] cmd, input logic [7:0] rx,
                           input logic [31:0] fsz, output bit counted);
    int gap;
    if (send_spell == 0) begin
      send_quiet = ($urandom_range(0, 2) == 0);
      send_spell = $urandom_range(10, 40);
    end
    send_spell--;
    gap = (send_quiet || rush) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.rx_byte   <= rx;
    in_ch.file_size <= fsz;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    counted = sb.note_word(cmd, rx, fsz);
  endtask

  task automatic send(input logic [2:0] cmd, input logic [7:0] rx, input logic [31:0] fsz);
    bit counted;
    send_word(cmd, rx, fsz, counted);
  endtask

  task automatic settle();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_file_size();
    logic [31:0] edges [9] = '{32'd127, 32'd128, 32'd129, 32'd1023, 32'd1024, 32'd1025,
                               32'd2047, 32'd2048, 32'd2049};
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 40) return $urandom_range(1, 300);
    if (roll < 70) return $urandom_range(0, 4200);
    if (roll < 85) return edges[$urandom_range(0, 8)];
    return $urandom;
  endfunction

  // mostly words that move the transfer forward, with noise mixed in
  task automatic pick_word(output logic [2:0] cmd, output logic [7:0] rx,
                           output logic [31:0] fsz);
    int roll;
    int lean;
    roll = $urandom_range(0, 99);
    lean = $urandom_range(0, 99);
    cmd  = CMD_BYTE;
    rx   = 8'($urandom);
    fsz  = $urandom;
    if (roll < 8) cmd = 3'($urandom_range(CMD_START, CMD_UNUSED_LAST));
    else if (roll < 12) cmd = CMD_CANCEL;
    else if (roll < 27) cmd = CMD_TICK;
    else begin
      case (sb.mode)
        MODE_IDLE: begin
          if (lean < 75) begin
            cmd = CMD_START;
            fsz = pick_file_size();
          end else cmd = CMD_END;
        end
        MODE_WAIT_REQ, MODE_DATA_REQ: rx = (lean < 80) ? BYTE_C : BYTE_NAK;
        default: rx = (lean < 78) ? BYTE_ACK : BYTE_NAK;
      endcase
    end
  endtask

  task automatic run_random(input int n);
    logic [2:0]  cmd;
    logic [7:0]  rx;
    logic [31:0] fsz;
    bit          counted;
    int          done;
    done = 0;
    while (done < n) begin
      pick_word(cmd, rx, fsz);
      send_word(cmd, rx, fsz, counted);
      if (counted) done++;
    end
  endtask

  task automatic run_directed();
    send(CMD_TICK, 8'h00, 32'hFFFF_FFFF);
    send(CMD_CANCEL, 8'hFF, 32'd0);
    send(CMD_UNUSED_FIRST, BYTE_C, 32'd5);
    send(CMD_UNUSED_LAST, BYTE_ACK, 32'd7);
    // empty file: header with one retry, nak on data request, then eot right away with one retry
    send(CMD_START, 8'h00, 32'd0);
    send(CMD_END, 8'h00, 32'd0);
    send(CMD_BYTE, 8'hFF, 32'd0);
    send(CMD_BYTE, BYTE_C, 32'd0);
    send(CMD_BYTE, BYTE_NAK, 32'd0);
    send(CMD_BYTE, BYTE_ACK, 32'd0);
    send(CMD_BYTE, BYTE_NAK, 32'd0);
    send(CMD_BYTE, BYTE_C, 32'd0);
    send(CMD_BYTE, BYTE_NAK, 32'd0);
    send(CMD_BYTE, BYTE_ACK, 32'd0);
    // close of the batch with one retry
    send(CMD_END, 8'h00, 32'd0);
    send(CMD_BYTE, BYTE_NAK, 32'd0);
    send(CMD_BYTE, BYTE_ACK, 32'd0);
    // largest file: two long blocks with a resend, then cancel
    send(CMD_START, 8'h00, 32'hFFFF_FFFF);
    send(CMD_BYTE, BYTE_NAK, 32'd0);
    send(CMD_BYTE, BYTE_ACK, 32'd0);
    send(CMD_BYTE, BYTE_C, 32'd0);
    send(CMD_BYTE, BYTE_NAK, 32'd0);
    send(CMD_BYTE, BYTE_ACK, 32'd0);
    send(CMD_CANCEL, 8'h00, 32'd0);
  endtask

  initial begin : action_sink
    int      gap;
    int      spell;
    bit      quiet;
    result_t got;
    out_ch.ready = 1'b0;
    spell = 0;
    quiet = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (spell == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
        spell = $urandom_range(10, 40);
      end
      spell--;
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end else gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.action      = action_t'(out_ch.action);
      got.seq         = out_ch.seq;
      got.long_block  = out_ch.long_block;
      got.data_offset = out_ch.data_offset;
      got.data_len    = out_ch.data_len;
      got.fail_reason = fail_t'(out_ch.fail_reason);
      sb.check_word(got);
    end
  end

  initial begin : stimulus
    logic [31:0] limits [PHASES];
    logic [31:0] retries [PHASES];
    sb = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_TICK;
    in_ch.rx_byte   = '0;
    in_ch.file_size = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_TIMEOUT_TICKS;
    cfg_data        = '0;
    rush            = 1'b0;
    hold_request    = 1'b0;
    holds_done      = 0;
    settings_used   = 1;
    send_spell      = 0;
    send_quiet      = 1'b0;
    limits  = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'd0, 32'd0, 32'd0};
    retries = '{32'd0, 32'd255, 32'd2, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0};
    for (int p = 4; p < PHASES; p++) begin
      limits[p]  = $urandom_range(1, 6);
      retries[p] = $urandom_range(0, 4);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_TIMEOUT_TICKS, limits[p]);
      write_reg(CFG_RETRY_LIMIT, retries[p]);
      settings_used++;
      if (p == PRESSURE_PHASE) begin
        rush = 1'b1;
        hold_request = 1'b1;
      end
      run_random(WORDS_PER_PHASE);
      rush = 1'b0;
      settle();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d action words never arrived", sb.pending()));

    $display("run covered %0d command words, %0d action words, %0d settings, %0d long holds",
             sb.words_in, sb.words_out, settings_used, holds_done);
    $display("hdr %0d data %0d eot %0d close %0d can %0d done %0d batch %0d (%0d failed)",
             sb.seen[ACT_HDR], sb.seen[ACT_DATA], sb.seen[ACT_EOT], sb.seen[ACT_CLOSE],
             sb.seen[ACT_CAN], sb.seen[ACT_FILE_DONE], sb.seen[ACT_BATCH],
             sb.failed_batches);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ysc_pkg.sv
hw/rtl/ysc_if.sv
hw/rtl/ysc_front.sv
hw/rtl/ysc_queue.sv
hw/rtl/ysc_back.sv
hw/rtl/ymodem_sender_controller_core.sv
tb/tb_ymodem_sender_controller_core.sv
